// ===== rtl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned IN_PRIO_W   = 16;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
`default_nettype none
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRIO_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire spq_ctrl_t            ctrl_i,
  input  wire logic [DATA_BITS-1:0] new_data_i,
  input  wire logic [PRIO_BITS-1:0] new_prio_i,
  input  wire logic                 prev_keep_i,
  input  wire logic [DATA_BITS-1:0] prev_data_i,
  input  wire logic [PRIO_BITS-1:0] prev_prio_i,
  input  wire logic [DATA_BITS-1:0] next_data_i,
  input  wire logic [PRIO_BITS-1:0] next_prio_i,
  input  wire logic                 valid_i,
  output logic                      keep_o,
  output logic [DATA_BITS-1:0]      data_o,
  output logic [PRIO_BITS-1:0]      prio_o
);

  logic [DATA_BITS-1:0] data_q, data_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;

  // held entry strictly ahead of the new one stays put
  assign keep_o = valid_i && (prio_q < new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctrl_i.enq && !keep_o) begin
      if (prev_keep_i) begin
        data_d = new_data_i;
        prio_d = new_prio_i;
      end else begin
        data_d = prev_data_i;
        prio_d = prev_prio_i;
      end
    end else if (ctrl_i.deq) begin
      data_d = next_data_i;
      prio_d = next_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue_core.sv =====
// The result is registered and presented in the cycle after the request is accepted.
// Throughput: one request per cycle while the result output is not stalled; every cell compares and shifts in parallel.
// A request is taken while the previous result is being taken downstream.
// Reset: asynchronous active low, clears entry count and result valid;
// cell contents are not reset and no clearing pass is needed.
`default_nettype none
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PRIO_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [31:0] item_data, [47:32] item_priority
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  wire logic                   s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [31:0] out_data, [47:32] out_priority, [52:48] entry_count, [55:53] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                  m_axis_tuser_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                 accept;
  logic                 enq_ok, deq_ok;
  spq_op_e              op;
  spq_ctrl_t            ctrl;
  logic [DATA_BITS-1:0] in_data;
  logic [PRIO_BITS-1:0] in_prio;
  logic [CW-1:0]        count_q, count_d;
  logic                 full, empty;

  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic                 cell_keep [DEPTH];

  logic                   out_valid_q;
  logic [DATA_BITS-1:0]   out_data_q, out_data_d;
  logic [IN_PRIO_W-1:0]   out_prio_q, out_prio_d;
  logic [COUNT_OUT_W-1:0] out_count_q;
  spq_status_e            out_status_q, out_status_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = spq_op_e'(s_axis_tuser_i);
  assign in_data         = s_axis_tdata_i[DATA_BITS-1:0];
  assign in_prio         = PRIO_BITS'(s_axis_tdata_i[IN_TDATA_W-1:DATA_BITS]);

  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);
  assign enq_ok = accept && (op == OP_ENQ) && !full;
  assign deq_ok = accept && (op == OP_DEQ) && !empty;
  assign ctrl   = '{enq: enq_ok, deq: deq_ok};

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_keep;
    logic [DATA_BITS-1:0] prev_data, next_data;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;
    logic                 valid;

    assign valid = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_data = in_data;
      assign prev_prio = in_prio;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
      assign prev_data = cell_data[i-1];
      assign prev_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_data = cell_data[i];
      assign next_prio = cell_prio[i];
    end else begin : g_link
      assign next_data = cell_data[i+1];
      assign next_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_data_i (in_data),
      .new_prio_i (in_prio),
      .prev_keep_i(prev_keep),
      .prev_data_i(prev_data),
      .prev_prio_i(prev_prio),
      .next_data_i(next_data),
      .next_prio_i(next_prio),
      .valid_i    (valid),
      .keep_o     (cell_keep[i]),
      .data_o     (cell_data[i]),
      .prio_o     (cell_prio[i])
    );
  end

  always_comb begin
    out_status_d = ST_DONE;
    out_data_d   = '0;
    out_prio_d   = '0;
    priority if (op == OP_ENQ && full) begin
      out_status_d = ST_FULL;
    end else if (op == OP_DEQ && empty) begin
      out_status_d = ST_EMPTY;
    end else if (op == OP_DEQ) begin
      out_data_d = cell_data[0];
      out_prio_d = IN_PRIO_W'(cell_prio[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_prio_q   <= out_prio_d;
      out_count_q  <= COUNT_OUT_W'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_prio_q, out_data_q};

endmodule
`default_nettype wire
